// File: design/rdn_pkg.sv
// ----------------------------------------------------------------------------
// rdn_pkg
// Shared types and constants for the ray direction normaliser.
// ----------------------------------------------------------------------------
`default_nettype none

package rdn_pkg;

	localparam int unsigned AXES = 3;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

	// Unit division: trunc(mag * 2^16 / len), quotient at most 2^16
	localparam int unsigned UQ_W = 17;
	// Reciprocal: 2^32 / unit magnitude, quotient up to 2^32
	localparam int unsigned IQ_W = 33;

	typedef logic [31:0] mag_t;
	typedef logic [UQ_W-1:0] uq_t;

	// Travels alongside the square root
	typedef struct packed {
		mag_t [AXES-1:0] mag;
		logic [AXES-1:0] neg;
		logic [30:0]     hit;
		logic            last;
		logic            winv;
	} sq_sb_t;

	// Travels alongside the unit division
	typedef struct packed {
		logic [AXES-1:0] neg;
		logic [30:0]     sdist;
		logic            dsat;
		logic            zero;
		logic            last;
		logic            winv;
	} ud_sb_t;

	// Travels alongside the reciprocal division
	typedef struct packed {
		ud_sb_t         ud;
		uq_t [AXES-1:0] uq;
	} iv_sb_t;

endpackage

`default_nettype wire

// File: design/rdn_if.sv
// ----------------------------------------------------------------------------
// rdn_if
// Channel interfaces of the ray direction normaliser.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdn_ray_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	logic        [30:0] hit_distance;
	logic               last_ray;

	modport source (output valid, dir_x, dir_y, dir_z, hit_distance, last_ray,
		input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, hit_distance, last_ray,
		output ready);
endinterface

interface rdn_ray_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] unit_x;
	logic signed [17:0] unit_y;
	logic signed [17:0] unit_z;
	logic        [30:0] scaled_distance;
	logic signed [31:0] inv_x;
	logic signed [31:0] inv_y;
	logic signed [31:0] inv_z;
	logic               zero_length;
	logic               saturated;
	logic               last_out;

	modport source (output valid, unit_x, unit_y, unit_z, scaled_distance,
		inv_x, inv_y, inv_z, zero_length, saturated, last_out, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, scaled_distance,
		inv_x, inv_y, inv_z, zero_length, saturated, last_out, output ready);
endinterface

interface rdn_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/ray_direction_normalize.sv
// Throughput: one ray per cycle; the square root (32 stages) and the two
// dividers (17 and 33 stages) each resolve one bit per stage.
// The whole pipeline advances together; it holds only while a result waits.
// Reset (arst_n low) clears all valid bits and winv_q; no clearing pass.
// ----------------------------------------------------------------------------
// ray_direction_normalize
// Normalises a Q16.16 ray direction, scales the hit distance by its length
// and optionally forms per-axis reciprocals of the unit direction.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_direction_normalize
	import rdn_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	rdn_cfg_if.sink     cfg,
	rdn_ray_in_if.sink  ray_in,
	rdn_ray_out_if.source ray_out
);

	logic   winv_q;
	logic   en;
	logic   out_v_q;

	assign en           = !out_v_q || ray_out.ready;
	assign ray_in.ready = en;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winv_q <= 1'b0;
		end else if (cfg.valid) begin
			winv_q <= cfg.data;
		end
	end

	// ---------------- stage 1: magnitudes
	logic            v_s1;
	mag_t [AXES-1:0] mag_s1;
	logic [AXES-1:0] neg_s1;
	logic [30:0]     hit_s1;
	logic            last_s1;
	logic            winv_s1;
	logic [31:0]     dir_in [AXES];

	assign dir_in[0] = ray_in.dir_x;
	assign dir_in[1] = ray_in.dir_y;
	assign dir_in[2] = ray_in.dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < AXES; j++) begin
				mag_s1[j] <= dir_in[j][31] ? 32'(-dir_in[j]) : dir_in[j];
				neg_s1[j] <= dir_in[j][31];
			end
			hit_s1  <= ray_in.hit_distance;
			last_s1 <= ray_in.last_ray;
			winv_s1 <= winv_q;
		end
	end

	// ---------------- stage 2: squares
	logic        v_s2;
	logic [63:0] sq_s2 [AXES];
	sq_sb_t      sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < AXES; j++) begin
				sq_s2[j] <= 64'(mag_s1[j]) * 64'(mag_s1[j]);
			end
			sb_s2.mag  <= mag_s1;
			sb_s2.neg  <= neg_s1;
			sb_s2.hit  <= hit_s1;
			sb_s2.last <= last_s1;
			sb_s2.winv <= winv_s1;
		end
	end

	// ---------------- stage 3: sum of squares (fits 64 bits)
	logic        v_s3;
	logic [63:0] sum_s3;
	sq_sb_t      sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sb_s3  <= sb_s2;
		end
	end

	// ---------------- square root
	logic        sq_v;
	logic [31:0] sq_root;
	sq_sb_t      sq_sb;

	rdn_sqrt #(
		.SBW ($bits(sq_sb_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.in_sb     (sb_s3),
		.out_valid (sq_v),
		.root      (sq_root),
		.out_sb    (sq_sb)
	);

	// ---------------- stage 4: distance product
	logic        v_s4;
	logic [62:0] prod_s4;
	logic [31:0] len_s4;
	sq_sb_t      sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= 63'(sq_sb.hit) * 63'(sq_root);
			len_s4  <= sq_root;
			sb_s4   <= sq_sb;
		end
	end

	// ---------------- unit division
	logic [31:0] ud_rem0 [AXES];
	logic [16:0] ud_lo   [AXES];
	logic [31:0] ud_dv   [AXES];
	ud_sb_t      ud_in_sb;
	logic        ud_v;
	logic [16:0] ud_q    [AXES];
	ud_sb_t      ud_sb;

	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			ud_rem0[j] = {1'b0, sb_s4.mag[j][31:1]};
			ud_lo[j]   = {sb_s4.mag[j][0], 16'h0000};
			ud_dv[j]   = len_s4;
		end
		ud_in_sb.neg   = sb_s4.neg;
		ud_in_sb.dsat  = |prod_s4[62:47];
		ud_in_sb.sdist = ud_in_sb.dsat ? DIST_MAX : prod_s4[46:16];
		ud_in_sb.zero  = (len_s4 == 32'd0);
		ud_in_sb.last  = sb_s4.last;
		ud_in_sb.winv  = sb_s4.winv;
	end

	rdn_div #(
		.LANES (AXES),
		.DW    (32),
		.QW    (UQ_W),
		.SBW   ($bits(ud_sb_t))
	) u_unit_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rem0      (ud_rem0),
		.low_bits  (ud_lo),
		.divisor   (ud_dv),
		.in_sb     (ud_in_sb),
		.out_valid (ud_v),
		.quotient  (ud_q),
		.out_sb    (ud_sb)
	);

	// ---------------- reciprocal division
	logic [16:0] iv_rem0 [AXES];
	logic [32:0] iv_lo   [AXES];
	iv_sb_t      iv_in_sb;
	logic        iv_v;
	logic [32:0] iv_q    [AXES];
	iv_sb_t      iv_sb;

	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			iv_rem0[j]     = '0;
			iv_lo[j]       = 33'h1_0000_0000;
			iv_in_sb.uq[j] = ud_q[j];
		end
		iv_in_sb.ud = ud_sb;
	end

	rdn_div #(
		.LANES (AXES),
		.DW    (UQ_W),
		.QW    (IQ_W),
		.SBW   ($bits(iv_sb_t))
	) u_inv_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ud_v),
		.rem0      (iv_rem0),
		.low_bits  (iv_lo),
		.divisor   (ud_q),
		.in_sb     (iv_in_sb),
		.out_valid (iv_v),
		.quotient  (iv_q),
		.out_sb    (iv_sb)
	);

	// ---------------- output stage: sign, clamp, zero vector
	logic [17:0] unit_c [AXES];
	logic [31:0] inv_c  [AXES];
	logic        sat_c;
	logic [17:0] unit_q [AXES];
	logic [31:0] inv_q  [AXES];
	logic [30:0] dist_q;
	logic        zero_q;
	logic        sat_q;
	logic        last_q;

	always_comb begin
		sat_c = iv_sb.ud.dsat;
		for (int j = 0; j < AXES; j++) begin
			unit_c[j] = iv_sb.ud.neg[j] ? 18'(-{1'b0, iv_sb.uq[j]})
				: {1'b0, iv_sb.uq[j]};
			inv_c[j]  = '0;
			if (iv_sb.ud.winv) begin
				if (iv_sb.uq[j] == '0) begin
					inv_c[j] = iv_sb.ud.neg[j] ? S32_MIN : S32_MAX;
					sat_c    = 1'b1;
				end else if (iv_sb.ud.neg[j]) begin
					if (iv_q[j] > 33'h0_8000_0000) begin
						inv_c[j] = S32_MIN;
						sat_c    = 1'b1;
					end else begin
						inv_c[j] = 32'(-iv_q[j]);
					end
				end else begin
					if (iv_q[j] > 33'h0_7FFF_FFFF) begin
						inv_c[j] = S32_MAX;
						sat_c    = 1'b1;
					end else begin
						inv_c[j] = iv_q[j][31:0];
					end
				end
			end
		end
		// zero vector: unit, reciprocal and saturation results clear
		if (iv_sb.ud.zero) begin
			sat_c = 1'b0;
			for (int j = 0; j < AXES; j++) begin
				unit_c[j] = '0;
				inv_c[j]  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= iv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_q <= unit_c;
			inv_q  <= inv_c;
			dist_q <= iv_sb.ud.zero ? 31'd0 : iv_sb.ud.sdist;
			zero_q <= iv_sb.ud.zero;
			sat_q  <= sat_c;
			last_q <= iv_sb.ud.last;
		end
	end

	assign ray_out.valid           = out_v_q;
	assign ray_out.unit_x          = unit_q[0];
	assign ray_out.unit_y          = unit_q[1];
	assign ray_out.unit_z          = unit_q[2];
	assign ray_out.inv_x           = inv_q[0];
	assign ray_out.inv_y           = inv_q[1];
	assign ray_out.inv_z           = inv_q[2];
	assign ray_out.scaled_distance = dist_q;
	assign ray_out.zero_length     = zero_q;
	assign ray_out.saturated       = sat_q;
	assign ray_out.last_out        = last_q;

`ifndef SYNTHESIS
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ray_out.valid && ray_out.zero_length |->
			ray_out.unit_x == 18'sd0 && ray_out.inv_y == 32'sd0 &&
			ray_out.scaled_distance == 31'd0 && !ray_out.saturated)
		else $error("zero vector result not cleared");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		ray_out.valid |->
			ray_out.unit_x <= 18'sd65536 && ray_out.unit_x >= -18'sd65536 &&
			ray_out.unit_z <= 18'sd65536 && ray_out.unit_z >= -18'sd65536)
		else $error("unit component beyond one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s4) && $stable(ud_v) && $stable(iv_v))
		else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

// File: design/rdn_sqrt.sv
// ----------------------------------------------------------------------------
// rdn_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rdn_sqrt #(
	parameter int unsigned SBW = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [63:0]    radicand,
	input  wire logic [SBW-1:0] in_sb,
	output logic                out_valid,
	output logic [31:0]         root,
	output logic [SBW-1:0]      out_sb
);

	localparam int unsigned STAGES = 32;

	logic           v_s    [1:STAGES];
	logic [33:0]    rem_s  [1:STAGES];
	logic [31:0]    root_s [1:STAGES];
	logic [63:0]    rad_s  [1:STAGES];
	logic [SBW-1:0] sb_s   [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic           v_p;
		logic [33:0]    rem_p;
		logic [31:0]    root_p;
		logic [63:0]    rad_p;
		logic [SBW-1:0] sb_p;
		logic [35:0]    rem_t;
		logic [35:0]    trial;
		logic [35:0]    diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = radicand;
			assign sb_p   = in_sb;
		end else begin : g_next
			assign v_p    = v_s[k];
			assign rem_p  = rem_s[k];
			assign root_p = root_s[k];
			assign rad_p  = rad_s[k];
			assign sb_p   = sb_s[k];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_t = {rem_p, rad_p[63:62]};
		assign trial = {2'b00, root_p, 2'b01};
		assign ge    = (rem_t >= trial);
		assign diff  = rem_t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[33:0] : rem_t[33:0];
				root_s[k+1] <= {root_p[30:0], ge};
				rad_s[k+1]  <= {rad_p[61:0], 2'b00};
				sb_s[k+1]   <= sb_p;
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign root      = root_s[STAGES];
	assign out_sb    = sb_s[STAGES];

endmodule

`default_nettype wire

// File: design/rdn_div.sv
// ----------------------------------------------------------------------------
// rdn_div
// Pipelined restoring divider, several lanes in lockstep, one quotient bit
// per stage. The starting remainder must lie below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rdn_div #(
	parameter int unsigned LANES = 3,
	parameter int unsigned DW    = 32,
	parameter int unsigned QW    = 17,
	parameter int unsigned SBW   = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [DW-1:0]  rem0     [LANES],
	input  wire logic [QW-1:0]  low_bits [LANES],
	input  wire logic [DW-1:0]  divisor  [LANES],
	input  wire logic [SBW-1:0] in_sb,
	output logic                out_valid,
	output logic [QW-1:0]       quotient [LANES],
	output logic [SBW-1:0]      out_sb
);

	logic           v_s   [1:QW];
	logic [DW-1:0]  rem_s [1:QW][LANES];
	logic [QW-1:0]  lo_s  [1:QW][LANES];
	logic [QW-1:0]  q_s   [1:QW][LANES];
	logic [DW-1:0]  dv_s  [1:QW][LANES];
	logic [SBW-1:0] sb_s  [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic           v_p;
		logic [DW-1:0]  rem_p [LANES];
		logic [QW-1:0]  lo_p  [LANES];
		logic [QW-1:0]  q_p   [LANES];
		logic [DW-1:0]  dv_p  [LANES];
		logic [SBW-1:0] sb_p;
		logic [DW:0]    rx    [LANES];
		logic [DW:0]    diff  [LANES];
		logic           ge    [LANES];

		if (k == 0) begin : g_first
			assign v_p   = in_valid;
			assign rem_p = rem0;
			assign lo_p  = low_bits;
			assign dv_p  = divisor;
			assign sb_p  = in_sb;
			for (genvar j = 0; j < LANES; j++) begin : g_q0
				assign q_p[j] = '0;
			end
		end else begin : g_next
			assign v_p   = v_s[k];
			assign rem_p = rem_s[k];
			assign lo_p  = lo_s[k];
			assign q_p   = q_s[k];
			assign dv_p  = dv_s[k];
			assign sb_p  = sb_s[k];
		end

		always_comb begin
			for (int j = 0; j < LANES; j++) begin
				rx[j]   = {rem_p[j], lo_p[j][QW-1]};
				diff[j] = rx[j] - {1'b0, dv_p[j]};
				ge[j]   = (rx[j] >= {1'b0, dv_p[j]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < LANES; j++) begin
					rem_s[k+1][j] <= ge[j] ? diff[j][DW-1:0] : rx[j][DW-1:0];
					lo_s[k+1][j]  <= {lo_p[j][QW-2:0], 1'b0};
					q_s[k+1][j]   <= {q_p[j][QW-2:0], ge[j]};
					dv_s[k+1][j]  <= dv_p[j];
				end
				sb_s[k+1] <= sb_p;
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quotient  = q_s[QW];
	assign out_sb    = sb_s[QW];

endmodule

`default_nettype wire
